// File: design/sorted_range_table_lookup_core_assert.svh
// Assertion macros shared by the range table RTL.
// Each macro expects clk and rst in scope; SYNTH builds drop the checks.
`ifndef SORTED_RANGE_TABLE_LOOKUP_CORE_ASSERT_SVH
`define SORTED_RANGE_TABLE_LOOKUP_CORE_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, quiet during reset.
`define SRTL_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("range table assertion failed");
// Next-cycle implication, quiet during reset.
`define SRTL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("range table assertion failed");
`else
`define SRTL_ASSERT(lbl, ante, cons)
`define SRTL_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: design/srtl_pkg.sv
// Shared types and constants of the sorted range table lookup block.
// No dependencies; srtl_if, srtl_search and the core import this package.
package srtl_pkg;

  localparam int ENTRIES   = 512;
  localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W     = $clog2(ENTRIES + 1);
  localparam int ADDR_W    = 64;
  localparam int OUT_IDX_W = 9;
  localparam int ENTRY_W   = 2 * ADDR_W;

  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_LOOKUP = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_FULL = 2'd1,
    ST_HIT  = 2'd2,
    ST_MISS = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROBE,
    S_CHECK
  } search_state_t;

  // One stored range: first address and exclusive end.
  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] limit;
  } entry_t;

  // One result item.
  typedef struct packed {
    status_t              status;
    logic [OUT_IDX_W-1:0] entry_index;
  } res_t;

  // Fit a table index to the reported index width (mask or zero-extend).
  function automatic logic [OUT_IDX_W-1:0] to_out_idx(input logic [IDX_W-1:0] idx);
    logic [OUT_IDX_W+IDX_W-1:0] wide;
    wide = {{OUT_IDX_W{1'b0}}, idx};
    return wide[OUT_IDX_W-1:0];
  endfunction

endpackage

// File: design/srtl_if.sv
// Valid/ready channel interfaces for the range table block.
// Depends on srtl_pkg for field widths.
interface srtl_req_if
  import srtl_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [1:0]        mode;
  logic [ADDR_W-1:0] range_start;
  logic [ADDR_W-1:0] range_end;
  logic [ADDR_W-1:0] query_addr;
  logic [ADDR_W-1:0] query_size;

  modport source (output valid, mode, range_start, range_end, query_addr, query_size,
                  input ready);
  modport sink (input valid, mode, range_start, range_end, query_addr, query_size,
                output ready);
endinterface

interface srtl_rsp_if
  import srtl_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [1:0]           status;
  logic [OUT_IDX_W-1:0] entry_index;

  modport source (output valid, status, entry_index, input ready);
  modport sink (input valid, status, entry_index, output ready);
endinterface

// File: design/srtl_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module srtl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic                                         re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/srtl_search.sv
// Binary search sequencer: probes the range memory one entry at a time (read, then compare).
// Depends on srtl_pkg and the assertion macro header.
`include "sorted_range_table_lookup_core_assert.svh"

module srtl_search
  import srtl_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [ADDR_W-1:0] addr,
  input  logic [ADDR_W-1:0] size,
  input  logic [CNT_W-1:0]  count,
  output logic              rd_en,
  output logic [IDX_W-1:0]  rd_addr,
  input  entry_t            rd_data,
  output logic              busy,
  output logic              done,
  output res_t              res
);

  search_state_t     state, state_next;
  logic [CNT_W-1:0]  lo, lo_next;
  logic [CNT_W-1:0]  hi, hi_next;
  logic [CNT_W-1:0]  cnt_q;
  logic [IDX_W-1:0]  mid_q;
  logic [ADDR_W-1:0] addr_q;
  logic [ADDR_W-1:0] sum_q;
  logic [CNT_W:0]    mid_sum;
  logic [CNT_W-1:0]  mid;
  logic              below;
  logic              above;
  logic              exact;

  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign mid     = mid_sum[CNT_W:1];
  assign below   = addr_q < rd_data.base;
  assign above   = addr_q >= rd_data.limit;
  assign exact   = (rd_data.base == addr_q) && (rd_data.limit == sum_q);
  assign busy    = (state != S_IDLE);

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Window bounds, probe index and query
  always_ff @(posedge clk) begin
    lo <= lo_next;
    hi <= hi_next;
    if (start) begin
      addr_q <= addr;
      sum_q  <= addr + size;
      cnt_q  <= count;
    end
    if (rd_en) begin
      mid_q <= mid[IDX_W-1:0];
    end
  end

  // Next state, window update and result
  always_comb begin
    state_next      = state;
    lo_next         = lo;
    hi_next         = hi;
    rd_en           = 1'b0;
    rd_addr         = mid[IDX_W-1:0];
    done            = 1'b0;
    res.status      = ST_MISS;
    res.entry_index = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          lo_next    = '0;
          hi_next    = count;
          state_next = S_PROBE;
        end
      end
      S_PROBE: begin
        // Empty window ends the search with a miss
        if (lo < hi) begin
          rd_en      = 1'b1;
          state_next = S_CHECK;
        end else begin
          done       = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_CHECK: begin
        if (below) begin
          hi_next    = CNT_W'(mid_q);
          state_next = S_PROBE;
        end else if (above) begin
          lo_next    = CNT_W'(mid_q) + CNT_W'(1);
          state_next = S_PROBE;
        end else begin
          // Candidate found: hit only on exact start and end
          done       = 1'b1;
          state_next = S_IDLE;
          if (exact) begin
            res.status      = ST_HIT;
            res.entry_index = to_out_idx(mid_q);
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `SRTL_ASSERT(a_start_when_idle, start, state == S_IDLE)
  `SRTL_ASSERT(a_check_after_read, state == S_CHECK, $past(rd_en))
  `SRTL_ASSERT(a_window_in_table, state != S_IDLE, hi <= cnt_q)
  `SRTL_ASSERT_NEXT(a_done_frees, done, !busy)

endmodule

// File: design/sorted_range_table_lookup_core.sv
// Clear and append register their result on acceptance; it moves to the output register
// when that is free and is then held until its transfer. A lookup probes one entry at a
// time (memory read, then compare), at most clog2(ENTRIES+1) probes plus a closing check
// of the empty window; its result then goes the same way. One item is in work at a time; the next input
// is taken while a finished result still waits on the output. Reset empties the table
// at once (entry count to zero); the range memory is not cleared.
`include "sorted_range_table_lookup_core_assert.svh"

module sorted_range_table_lookup_core
  import srtl_pkg::*;
(
  input logic      clk,
  input logic      rst,
  srtl_req_if.sink req,
  srtl_rsp_if.source rsp
);

  logic             busy;
  logic             res_pend;
  res_t             res;
  logic             out_valid;
  res_t             out_res;
  logic [CNT_W-1:0] entry_count;
  logic             accept;
  logic             full;
  logic             wr_en;
  logic             search_start;
  logic             search_busy;
  logic             search_done;
  res_t             search_res;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t           wr_entry;
  logic             out_free;
  logic             move;

  assign req.ready       = !busy;
  assign accept          = req.valid && !busy;
  assign full            = (entry_count == CNT_W'(ENTRIES));
  assign wr_en           = accept && (req.mode == MODE_APPEND) && !full;
  assign search_start    = accept && (req.mode == MODE_LOOKUP);
  assign wr_entry.base   = req.range_start;
  assign wr_entry.limit  = req.range_end;
  assign out_free        = !out_valid || rsp.ready;
  assign move            = res_pend && out_free;
  assign rsp.valid       = out_valid;
  assign rsp.status      = out_res.status;
  assign rsp.entry_index = out_res.entry_index;

  // Item tracking and entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      res_pend    <= 1'b0;
      entry_count <= '0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
        case (req.mode)
          MODE_CLEAR: begin
            entry_count <= '0;
          end
          MODE_APPEND: begin
            if (!full) begin
              entry_count <= entry_count + CNT_W'(1);
            end
          end
          default: begin
          end
        endcase
      end
      if ((accept && (req.mode != MODE_LOOKUP)) || search_done) begin
        res_pend <= 1'b1;
      end else if (move) begin
        res_pend <= 1'b0;
        busy     <= 1'b0;
      end
    end
  end

  // Result of the item in work
  always_ff @(posedge clk) begin
    if (accept && (req.mode != MODE_LOOKUP)) begin
      res.status      <= (req.mode == MODE_APPEND && full) ? ST_FULL : ST_DONE;
      res.entry_index <= '0;
    end else if (search_done) begin
      res <= search_res;
    end
  end

  // Output register: hold until transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_res <= res;
    end
  end

  srtl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (entry_count[IDX_W-1:0]),
    .wdata (wr_entry),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  srtl_search u_search (
    .clk     (clk),
    .rst     (rst),
    .start   (search_start),
    .addr    (req.query_addr),
    .size    (req.query_size),
    .count   (entry_count),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (entry_t'(ram_rdata)),
    .busy    (search_busy),
    .done    (search_done),
    .res     (search_res)
  );

  `SRTL_ASSERT(a_no_write_in_search, wr_en, !search_busy)
  `SRTL_ASSERT(a_count_bounded, 1'b1, entry_count <= CNT_W'(ENTRIES))
  `SRTL_ASSERT(a_out_from_pending, $rose(out_valid), $past(res_pend))
  `SRTL_ASSERT(a_search_only_busy, search_busy, busy && !res_pend)

endmodule

// File: verif/tb_sorted_range_table_lookup_core.sv
// Testbench for sorted_range_table_lookup_core: drives clear, append and lookup transfers
// and checks every result against a scoreboard that keeps its own copy of the range table.
// Depends on srtl_pkg and the channel interfaces in srtl_if.sv.
module tb_sorted_range_table_lookup_core;
  timeunit 1ns;
  timeprecision 1ps;
  import srtl_pkg::*;

  localparam logic [1:0]        MODE_UNUSED = 2'd3;
  localparam logic [ADDR_W-1:0] ADDR_MAX    = '1;
  localparam int                CYCLE_LIMIT = 250000;
  localparam int                SETTLE      = 40;
  localparam int                RANDOM_ITEMS = 600;

  // Expected results and a private copy of the range table.
  class range_lookup_sb;
    logic [ADDR_W-1:0] base_mem[ENTRIES];
    logic [ADDR_W-1:0] limit_mem[ENTRIES];
    int unsigned       used;
    res_t              expected_q[$];
    int                errors;
    int                hits;
    int                misses;
    int                drops;

    function void note_request(input logic [1:0] mode, input logic [ADDR_W-1:0] rs,
                               input logic [ADDR_W-1:0] re, input logic [ADDR_W-1:0] qa,
                               input logic [ADDR_W-1:0] qs);
      res_t        r;
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      bit          found;
      r.status      = ST_DONE;
      r.entry_index = '0;
      case (mode)
        MODE_CLEAR: begin
          used = 0;
        end
        MODE_APPEND: begin
          if (used >= ENTRIES) begin
            r.status = ST_FULL;
            drops++;
          end else begin
            base_mem[used]  = rs;
            limit_mem[used] = re;
            used++;
          end
        end
        MODE_LOOKUP: begin
          // Binary search over [lo, hi); stop on the first range holding the address.
          r.status = ST_MISS;
          lo       = 0;
          hi       = used;
          found    = 1'b0;
          mid      = 0;
          while (lo < hi && !found) begin
            mid = (lo + hi) / 2;
            if (qa < base_mem[mid]) hi = mid;
            else if (qa >= limit_mem[mid]) lo = mid + 1;
            else found = 1'b1;
          end
          if (found && base_mem[mid] == qa && limit_mem[mid] == qa + qs) begin
            r.status      = ST_HIT;
            r.entry_index = mid[OUT_IDX_W-1:0];
          end
          if (r.status == ST_HIT) hits++;
          else misses++;
        end
        default: begin
        end
      endcase
      expected_q.push_back(r);
    endfunction

    task report(input string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      errors++;
    endtask

    task check_response(input logic [1:0] st, input logic [OUT_IDX_W-1:0] idx);
      res_t r;
      if (expected_q.size() == 0) begin
        report($sformatf("result status=%0d index=%0d with nothing pending", st, idx));
      end else begin
        r = expected_q.pop_front();
        if (st !== r.status)
          report($sformatf("status %0d, wanted %0d", st, r.status));
        if (idx !== r.entry_index)
          report($sformatf("entry_index %0d, wanted %0d", idx, r.entry_index));
      end
    endtask
  endclass

  logic clk;
  logic rst;
  bit   steady;
  int   cycle_count = 0;
  int   items_sent;

  range_lookup_sb    sb;
  logic [ADDR_W-1:0] cursor;
  logic [ADDR_W-1:0] span_base_q[$];
  logic [ADDR_W-1:0] span_limit_q[$];

  srtl_req_if req_ch();
  srtl_rsp_if rsp_ch();

  sorted_range_table_lookup_core u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Stall the result side at random unless in a steady stretch.
  always @(negedge clk) begin
    rsp_ch.ready <= steady || ($urandom_range(0, 99) >= 16);
  end

  // Check each result transfer.
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready)
      sb.check_response(rsp_ch.status, rsp_ch.entry_index);
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results pending",
               cycle_count, sb.expected_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic [ADDR_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Present one item and hold it until its transfer; return at the next falling edge.
  task automatic send_item(input logic [1:0] mode, input logic [ADDR_W-1:0] rs,
                           input logic [ADDR_W-1:0] re, input logic [ADDR_W-1:0] qa,
                           input logic [ADDR_W-1:0] qs);
    while (!steady && $urandom_range(0, 99) < 16) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.mode        <= mode;
    req_ch.range_start <= rs;
    req_ch.range_end   <= re;
    req_ch.query_addr  <= qa;
    req_ch.query_size  <= qs;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sb.note_request(mode, rs, re, qa, qs);
    items_sent++;
    @(negedge clk);
  endtask

  // Hold off new input until every pending result has come back.
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(negedge clk);
    while (sb.expected_q.size() != 0) @(negedge clk);
  endtask

  // Append n ranges in ascending order, optionally after a clear; a few are empty or out of order.
  task automatic add_ranges(input int n, input bit fresh);
    logic [ADDR_W-1:0] rs;
    logic [ADDR_W-1:0] re;
    logic [ADDR_W-1:0] gap;
    logic [ADDR_W-1:0] len;
    if (fresh) begin
      send_item(MODE_CLEAR, rand64(), rand64(), rand64(), rand64());
      span_base_q.delete();
      span_limit_q.delete();
      cursor = rand64();
      if (cursor > ADDR_MAX - 64'h1_0000_0000) cursor = cursor - 64'h10_0000_0000;
    end
    repeat (n) begin
      case ($urandom_range(0, 3))
        0:       gap = '0;
        1:       gap = 64'($urandom_range(1, 16));
        2:       gap = 64'($urandom_range(1, 1 << 20));
        default: gap = 64'($urandom_range(17, 4096));
      endcase
      case ($urandom_range(0, 3))
        0:       len = 64'd1;
        1:       len = 64'($urandom_range(2, 256));
        2:       len = 64'($urandom_range(1, 1 << 20));
        default: len = 64'($urandom_range(1, 64));
      endcase
      rs = cursor + gap;
      re = rs + len;
      if ($urandom_range(0, 11) == 0) begin
        // empty or inverted range
        re = ($urandom_range(0, 1) != 0) ? rs : rs - 64'($urandom_range(1, 8));
        cursor = rs;
      end else if ($urandom_range(0, 24) == 0) begin
        // out of order, cursor untouched
        rs = rand64();
        re = rs + 64'($urandom_range(1, 4096));
      end else begin
        cursor = re;
      end
      span_base_q.push_back(rs);
      span_limit_q.push_back(re);
      send_item(MODE_APPEND, rs, re, rand64(), rand64());
    end
  endtask

  // Look up near a known range: exact hits, wrong sizes, inner and outer addresses.
  task automatic send_lookup();
    logic [ADDR_W-1:0] qa;
    logic [ADDR_W-1:0] qs;
    logic [ADDR_W-1:0] b;
    logic [ADDR_W-1:0] l;
    int                i;
    if (span_base_q.size() == 0) begin
      qa = rand64();
      qs = rand64();
    end else begin
      i = $urandom_range(0, span_base_q.size() - 1);
      b = span_base_q[i];
      l = span_limit_q[i];
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin qa = b; qs = l - b; end
        4:          begin qa = b; qs = l - b + 64'($urandom_range(1, 3)); end
        5:          begin qa = b + 64'($urandom_range(0, 255)); qs = l - qa; end
        6:          begin qa = l; qs = 64'($urandom_range(0, 255)); end
        7:          begin qa = b - 64'd1; qs = l - qa; end
        8:          begin qa = rand64(); qs = rand64(); end
        default:    begin qa = b; qs = rand64() | 64'h8000_0000_0000_0000; end
      endcase
    end
    send_item(MODE_LOOKUP, rand64(), rand64(), qa, qs);
  endtask

  // Random item of any mode, unused mode included.
  task automatic send_noise();
    case ($urandom_range(0, 9))
      0:          send_item(MODE_CLEAR, rand64(), rand64(), rand64(), rand64());
      1, 2, 3, 4: send_item(MODE_UNUSED, rand64(), rand64(), rand64(), rand64());
      5, 6, 7:    send_item(MODE_LOOKUP, rand64(), rand64(), rand64(), rand64());
      default:    send_item(MODE_APPEND, rand64(), rand64(), rand64(), rand64());
    endcase
  endtask

  // Fill the whole table without idling, overflow it, then search it.
  task automatic fill_table();
    steady = 1'b1;
    add_ranges(ENTRIES, 1'b1);
    repeat (4) send_item(MODE_APPEND, rand64(), rand64(), rand64(), rand64());
    steady = 1'b0;
    repeat (40) send_lookup();
    drain();
  endtask

  initial begin
    int rand_first;
    int n;
    int phase;
    sb                 = new();
    rst                = 1'b1;
    steady             = 1'b0;
    items_sent         = 0;
    cursor             = '0;
    req_ch.valid       = 1'b0;
    req_ch.mode        = MODE_CLEAR;
    req_ch.range_start = '0;
    req_ch.range_end   = '0;
    req_ch.query_addr  = '0;
    req_ch.query_size  = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty table, unused mode, edge ranges, exactness, wrap, unsorted table.
    send_item(MODE_LOOKUP, '0, '0, '0, '0);
    send_item(MODE_UNUSED, ADDR_MAX, ADDR_MAX, ADDR_MAX, ADDR_MAX);
    send_item(MODE_APPEND, '0, 64'h1, '0, '0);
    send_item(MODE_APPEND, 64'h100, 64'h200, '0, '0);
    send_item(MODE_APPEND, 64'h300, 64'h300, '0, '0);
    send_item(MODE_APPEND, 64'h400, 64'h3F0, '0, '0);
    send_item(MODE_APPEND, ADDR_MAX - 64'h100, ADDR_MAX, '0, '0);
    send_item(MODE_LOOKUP, '0, '0, '0, 64'h1);
    send_item(MODE_LOOKUP, '0, '0, 64'h100, 64'h100);
    send_item(MODE_LOOKUP, '0, '0, 64'h100, 64'h80);
    send_item(MODE_LOOKUP, '0, '0, 64'h180, 64'h80);
    send_item(MODE_LOOKUP, '0, '0, 64'h300, '0);
    send_item(MODE_LOOKUP, '0, '0, 64'h250, 64'h10);
    send_item(MODE_LOOKUP, '0, '0, ADDR_MAX - 64'h100, 64'hFF);
    send_item(MODE_LOOKUP, '0, '0, ADDR_MAX - 64'h100, ADDR_MAX);
    send_item(MODE_LOOKUP, '0, '0, ADDR_MAX, 64'h1);
    send_item(MODE_CLEAR, ADDR_MAX, ADDR_MAX, ADDR_MAX, ADDR_MAX);
    send_item(MODE_LOOKUP, '0, '0, '0, 64'h1);
    send_item(MODE_APPEND, 64'h5000, 64'h6000, '0, '0);
    send_item(MODE_APPEND, 64'h1000, 64'h2000, '0, '0);
    send_item(MODE_APPEND, 64'h5800, 64'h7000, '0, '0);
    send_item(MODE_LOOKUP, '0, '0, 64'h1000, 64'h1000);
    send_item(MODE_LOOKUP, '0, '0, 64'h5800, 64'h1800);
    send_item(MODE_LOOKUP, '0, '0, 64'h5000, 64'h1000);
    drain();

    // Random: tables of sorted ranges with targeted lookups, plus one full table.
    rand_first = items_sent;
    phase      = 0;
    while (items_sent - rand_first < RANDOM_ITEMS) begin
      if (phase == 2) begin
        fill_table();
      end else begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 80) : $urandom_range(1, 12);
        add_ranges(n, $urandom_range(0, 3) != 0);
        repeat (n + $urandom_range(2, 10)) begin
          if ($urandom_range(0, 9) == 0) send_noise();
          else send_lookup();
        end
        if ($urandom_range(0, 3) == 0) drain();
      end
      phase++;
    end

    drain();
    repeat (SETTLE) @(posedge clk);
    $display("Sent %0d transfers in %0d table phases over %0d cycles",
             items_sent, phase, cycle_count);
    $display("Lookups: %0d hits, %0d misses; %0d appends dropped on a full table",
             sb.hits, sb.misses, sb.drops);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.errors, sb.expected_q.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+design
design/srtl_pkg.sv
design/srtl_if.sv
design/srtl_ram.sv
design/srtl_search.sv
design/sorted_range_table_lookup_core.sv
verif/tb_sorted_range_table_lookup_core.sv
